### design/afpm_pkg.sv
// ----------------------------------------------------------------------------
// afpm_pkg
// Shared types, codes and helpers of the aspect-fit pixel mapper.
// ----------------------------------------------------------------------------
package afpm_pkg;

  // Largest accepted source dimension
  localparam logic [15:0] MAX_DIMENSION = 16'd65535;

  localparam int DIM_W      = 16;
  localparam int MARGIN_W   = 15;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 1;

  // Opcodes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Pixel formats
  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_RGB888 = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  // Reciprocals for exact truncating division of c*255 by 31 and by 63
  localparam int Exp5Recip = 8457;
  localparam int Exp5Shift = 18;
  localparam int Exp6Recip = 16645;
  localparam int Exp6Shift = 20;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic div_start;
    logic fit;
    logic margin;
    logic place;
    logic addr;
    logic load_out;
  } afpm_cmd_t;

  typedef struct packed {
    logic is_begin;
    logic begin_fail;
    logic need_scale;
    logic pix_in;
    logic div_done;
  } afpm_status_t;

  typedef struct packed {
    logic [7:0]          blue;
    logic [7:0]          green;
    logic [7:0]          red;
    logic [ADDR_W-1:0]   canvas_address;
    logic                write_enable;
    logic [MARGIN_W-1:0] margin_y;
    logic [MARGIN_W-1:0] margin_x;
    logic [DIM_W-1:0]    fit_height;
    logic [DIM_W-1:0]    fit_width;
    logic                fit_ok;
  } afpm_result_t;

  // 5-bit channel to 8 bits: floor(c * 255 / 31)
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] v;
    logic [26:0] p;
    v = 13'(c) * 13'd255;
    p = 27'(v) * 27'(Exp5Recip);
    return p[Exp5Shift+7:Exp5Shift];
  endfunction

  // 6-bit channel to 8 bits: floor(c * 255 / 63)
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] v;
    logic [28:0] p;
    v = 14'(c) * 14'd255;
    p = 29'(v) * 29'(Exp6Recip);
    return p[Exp6Shift+7:Exp6Shift];
  endfunction

endpackage

### design/afpm_div.sv
// ----------------------------------------------------------------------------
// afpm_div
// Restoring divider, one quotient bit per cycle. Full mode divides a 32-bit
// dividend in 32 steps; short mode takes 16 steps and needs the upper half
// of the dividend below the divisor, giving a 16-bit quotient.
// ----------------------------------------------------------------------------
module afpm_div import afpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              full_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [DIM_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [PROD_W-1:0] quotient_o
);

  localparam int CntW = $clog2(PROD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              full_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DIM_W-1:0]  rem_q, rem_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [DIM_W-1:0]  dvs_q;
  logic [DIM_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[PROD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      if (full_i) begin
        cnt_d = CntW'(PROD_W);
        rem_d = '0;
        quo_d = dividend_i;
      end else begin
        cnt_d = CntW'(DIM_W);
        rem_d = dividend_i[PROD_W-1:DIM_W];
        quo_d = {dividend_i[DIM_W-1:0], {DIM_W{1'b0}}};
      end
    end else if (busy_q) begin
      rem_d = ge ? DIM_W'(trial - {1'b0, dvs_q}) : trial[DIM_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      full_q <= full_i;
      dvs_q  <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = full_q ? quo_q : {{DIM_W{1'b0}}, quo_q[DIM_W-1:0]};

  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider busy with empty step count");

endmodule

### design/afpm_datapath.sv
// ----------------------------------------------------------------------------
// afpm_datapath
// Canvas registers, held fit, products, two dividers, placement and the
// result register.
// ----------------------------------------------------------------------------
module afpm_datapath import afpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 opcode_i,
  input  logic [DIM_W-1:0]     image_width_i,
  input  logic [DIM_W-1:0]     image_height_i,
  input  logic [DIM_W-1:0]     pixel_x_i,
  input  logic [DIM_W-1:0]     pixel_y_i,
  input  logic                 pixel_format_i,
  input  logic [23:0]          pixel_value_i,
  input  afpm_cmd_t            cmd_i,
  output afpm_status_t         status_o,
  output afpm_result_t         result_o
);

  logic [DIM_W-1:0]    canvas_w_q, canvas_h_q;
  logic                fit_valid_q;
  logic [DIM_W-1:0]    src_w_q, src_h_q, fit_w_q, fit_h_q;
  logic [MARGIN_W-1:0] mgn_x_q, mgn_y_q;

  logic                in_op_q, in_fmt_q;
  logic [DIM_W-1:0]    in_iw_q, in_ih_q, in_x_q, in_y_q;
  logic [23:0]         in_val_q;

  logic [PROD_W-1:0]   prod_a_q, prod_b_q;
  logic [PROD_W-1:0]   quo_a, quo_b;
  logic                done_a, done_b;
  logic                map_ok_q;
  logic [DIM_W:0]      cx_q, cy_q;
  logic [ADDR_W-1:0]   mul_q;
  afpm_result_t        result_q, result_d;

  logic                is_begin;
  logic [DIM_W-1:0]    fw_d, fh_d, fw_sel, fh_sel;
  logic [DIM_W-1:0]    dx_w, dy_w;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= '0;
      canvas_h_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i;
        REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latch the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_op_q  <= opcode_i;
      in_iw_q  <= image_width_i;
      in_ih_q  <= image_height_i;
      in_x_q   <= pixel_x_i;
      in_y_q   <= pixel_y_i;
      in_fmt_q <= pixel_format_i;
      in_val_q <= pixel_value_i;
    end
  end

  assign is_begin = (in_op_q == OP_BEGIN);

  always_comb begin
    status_o.is_begin   = is_begin;
    status_o.begin_fail = (canvas_w_q == '0) || (canvas_h_q == '0) ||
                          (in_iw_q == '0) || (in_ih_q == '0) ||
                          (in_iw_q > MAX_DIMENSION) || (in_ih_q > MAX_DIMENSION);
    status_o.need_scale = (in_iw_q > canvas_w_q) || (in_ih_q > canvas_h_q);
    status_o.pix_in     = fit_valid_q && (src_w_q != '0) && (src_h_q != '0) &&
                          (in_x_q < src_w_q) && (in_y_q < src_h_q);
    status_o.div_done   = done_a && done_b;
  end

  // Products for the dividers
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      prod_a_q <= is_begin ? PROD_W'(in_ih_q) * PROD_W'(canvas_w_q)
                           : PROD_W'(in_x_q) * PROD_W'(fit_w_q);
      prod_b_q <= is_begin ? PROD_W'(in_iw_q) * PROD_W'(canvas_h_q)
                           : PROD_W'(in_y_q) * PROD_W'(fit_h_q);
    end
  end

  afpm_div u_div_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .full_i     (is_begin),
    .dividend_i (prod_a_q),
    .divisor_i  (is_begin ? in_iw_q : src_w_q),
    .done_o     (done_a),
    .quotient_o (quo_a)
  );

  afpm_div u_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .full_i     (is_begin),
    .dividend_i (prod_b_q),
    .divisor_i  (is_begin ? in_ih_q : src_h_q),
    .done_o     (done_b),
    .quotient_o (quo_b)
  );

  // Fit selection: limit by width first, fall back to height
  always_comb begin
    if (!status_o.need_scale) begin
      fw_sel = in_iw_q;
      fh_sel = in_ih_q;
    end else if (quo_a <= PROD_W'(canvas_h_q)) begin
      fw_sel = canvas_w_q;
      fh_sel = quo_a[DIM_W-1:0];
    end else begin
      fw_sel = quo_b[DIM_W-1:0];
      fh_sel = canvas_h_q;
    end
    fw_d = (fw_sel == '0) ? DIM_W'(1) : fw_sel;
    fh_d = (fh_sel == '0) ? DIM_W'(1) : fh_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_valid_q <= 1'b0;
      src_w_q     <= '0;
      src_h_q     <= '0;
      fit_w_q     <= '0;
      fit_h_q     <= '0;
      mgn_x_q     <= '0;
      mgn_y_q     <= '0;
    end else begin
      if (cmd_i.fit) begin
        if (status_o.begin_fail) begin
          fit_valid_q <= 1'b0;
        end else begin
          fit_valid_q <= 1'b1;
          src_w_q     <= in_iw_q;
          src_h_q     <= in_ih_q;
          fit_w_q     <= fw_d;
          fit_h_q     <= fh_d;
        end
      end
      if (cmd_i.margin) begin
        mgn_x_q <= MARGIN_W'((canvas_w_q - fit_w_q) >> 1);
        mgn_y_q <= MARGIN_W'((canvas_h_q - fit_h_q) >> 1);
      end
    end
  end

  // Placement on the canvas
  assign dx_w = quo_a[DIM_W-1:0];
  assign dy_w = quo_b[DIM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      map_ok_q <= status_o.pix_in;
    end
    if (cmd_i.place) begin
      cx_q     <= (DIM_W+1)'(mgn_x_q) + (DIM_W+1)'(dx_w);
      cy_q     <= (DIM_W+1)'(mgn_y_q) + (DIM_W+1)'(dy_w);
      map_ok_q <= map_ok_q && (quo_a < PROD_W'(fit_w_q)) && (quo_b < PROD_W'(fit_h_q));
    end
    if (cmd_i.addr) begin
      mul_q    <= ADDR_W'(cy_q[DIM_W-1:0]) * ADDR_W'(canvas_w_q);
      map_ok_q <= map_ok_q && (cx_q < (DIM_W+1)'(canvas_w_q)) &&
                  (cy_q < (DIM_W+1)'(canvas_h_q));
    end
  end

  // Result assembly
  always_comb begin
    result_d                 = '0;
    result_d.fit_ok          = fit_valid_q;
    result_d.fit_width       = fit_w_q;
    result_d.fit_height      = fit_h_q;
    result_d.margin_x        = mgn_x_q;
    result_d.margin_y        = mgn_y_q;
    if (!is_begin) begin
      result_d.write_enable   = map_ok_q;
      result_d.canvas_address = map_ok_q ? mul_q + ADDR_W'(cx_q) : '0;
      if (in_fmt_q == FMT_RGB888) begin
        result_d.red   = in_val_q[23:16];
        result_d.green = in_val_q[15:8];
        result_d.blue  = in_val_q[7:0];
      end else begin
        result_d.red   = expand5(in_val_q[15:11]);
        result_d.green = expand6(in_val_q[10:5]);
        result_d.blue  = expand5(in_val_q[4:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

  a_fit_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_valid_q |-> (fit_w_q != '0) && (fit_h_q != '0) &&
                    (src_w_q != '0) && (src_h_q != '0))
    else $error("held fit valid with a zero dimension");

endmodule

### design/afpm_ctrl.sv
// ----------------------------------------------------------------------------
// afpm_ctrl
// Sequencer for one item at a time and valid bit of the output register.
// ----------------------------------------------------------------------------
module afpm_ctrl import afpm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         m_ready_i,
  input  afpm_status_t status_i,
  output logic         s_ready_o,
  output logic         m_valid_o,
  output afpm_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_FIT    = 4'd4;
  localparam logic [3:0] S_MARGIN = 4'd5;
  localparam logic [3:0] S_PLACE  = 4'd6;
  localparam logic [3:0] S_ADDR   = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = accept;
    cmd_o.prep      = (state_q == S_PREP);
    cmd_o.div_start = (state_q == S_START);
    cmd_o.fit       = (state_q == S_FIT);
    cmd_o.margin    = (state_q == S_MARGIN);
    cmd_o.place     = (state_q == S_PLACE);
    cmd_o.addr      = (state_q == S_ADDR);
    cmd_o.load_out  = (state_q == S_RESULT) && (!out_valid_q || m_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_PREP;
      S_PREP: begin
        if (status_i.is_begin) begin
          state_d = (status_i.begin_fail || !status_i.need_scale) ? S_FIT : S_START;
        end else begin
          state_d = status_i.pix_in ? S_START : S_RESULT;
        end
      end
      S_START:  state_d = S_DIV;
      S_DIV: begin
        if (status_i.div_done) state_d = status_i.is_begin ? S_FIT : S_PLACE;
      end
      S_FIT:    state_d = status_i.begin_fail ? S_RESULT : S_MARGIN;
      S_MARGIN: state_d = S_RESULT;
      S_PLACE:  state_d = S_ADDR;
      S_ADDR:   state_d = S_RESULT;
      S_RESULT: if (cmd_o.load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_PREP))
    else $error("accepted beat did not enter preparation");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the wait state");

endmodule

### design/aspect_fit_pixel_mapper_unit.sv
// ----------------------------------------------------------------------------
// aspect_fit_pixel_mapper_unit
// Aspect-preserving fit into a canvas and nearest-neighbor pixel placement.
// ----------------------------------------------------------------------------
// Write canvas width (index 0) and height (index 1) on the cfg port while
// the block is idle. Send a begin beat (tuser opcode 0) with the source size;
// the block fits it into the canvas without upscaling, centers it and holds
// the fit. Each pixel beat (opcode 1) returns one result beat with the canvas
// word address, a write enable and the color widened to 8 bits per channel.
// One beat at a time: s_axis_tready rises as the previous result is
// registered. A pixel in the held image runs prep, two 16-step restoring
// dividers side by side, place and address; one off the image or with no valid
// fit goes from prep to the result. A scaling begin runs the dividers (32
// steps), fit and margin; an as-is fit skips the dividers, a failed one both.
// Reset clears the canvas size and the held fit (no valid fit). The result
// waits in an output register while m_axis_tready is low; the next beat is
// accepted and processed meanwhile, and holds before its result until the
// register is free.
// ----------------------------------------------------------------------------
module aspect_fit_pixel_mapper_unit import afpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // image_width[15:0], image_height[31:16], pixel_x[47:32], pixel_y[63:48],
  // pixel_value[87:64]
  input  logic [87:0]          s_axis_tdata,
  // opcode[0], pixel_format[1]
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // fit_ok[0], fit_width[16:1], fit_height[32:17], margin_x[47:33],
  // margin_y[62:48], write_enable[63], canvas_address[95:64], red_out[103:96],
  // green_out[111:104], blue_out[119:112]
  output logic [119:0]         m_axis_tdata
);

  afpm_cmd_t    cmd;
  afpm_status_t status;
  afpm_result_t result;

  // Sequencer: accept, step the datapath, hand over to the output register
  afpm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  // Datapath: unpack the beat fields straight from the bus
  afpm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (s_axis_tuser[0]),
    .image_width_i  (s_axis_tdata[15:0]),
    .image_height_i (s_axis_tdata[31:16]),
    .pixel_x_i      (s_axis_tdata[47:32]),
    .pixel_y_i      (s_axis_tdata[63:48]),
    .pixel_format_i (s_axis_tuser[1]),
    .pixel_value_i  (s_axis_tdata[87:64]),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result)
  );

  // Pack the result beat, first field in the lowest bits
  assign m_axis_tdata = {result.blue, result.green, result.red,
                         result.canvas_address, result.write_enable,
                         result.margin_y, result.margin_x,
                         result.fit_height, result.fit_width, result.fit_ok};

endmodule

### test/mapper_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapper_result_checker
// Watches the config port and both stream channels of the aspect-fit pixel
// mapper, predicts every result beat from the accepted input beats and
// compares the two field by field, in order.
// ----------------------------------------------------------------------------
module mapper_result_checker import afpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [87:0]          s_tdata_i,
  input  logic [1:0]           s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [119:0]         m_tdata_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  // Result beat, lowest field last
  typedef struct packed {
    logic [7:0]          blue;
    logic [7:0]          green;
    logic [7:0]          red;
    logic [ADDR_W-1:0]   canvas_address;
    logic                write_enable;
    logic [MARGIN_W-1:0] margin_y;
    logic [MARGIN_W-1:0] margin_x;
    logic [DIM_W-1:0]    fit_height;
    logic [DIM_W-1:0]    fit_width;
    logic                fit_ok;
  } placement_t;

  typedef struct packed {
    logic                valid;
    logic [DIM_W-1:0]    src_w;
    logic [DIM_W-1:0]    src_h;
    logic [DIM_W-1:0]    fit_w;
    logic [DIM_W-1:0]    fit_h;
    logic [MARGIN_W-1:0] margin_x;
    logic [MARGIN_W-1:0] margin_y;
  } held_fit_t;

  logic [DIM_W-1:0] canvas_w;
  logic [DIM_W-1:0] canvas_h;
  held_fit_t        held;
  placement_t       expected_placements[$];
  placement_t       seen;
  placement_t       want;
  int               mismatches = 0;
  int               waiting = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = waiting;

  function automatic logic [7:0] widen_channel(input logic [31:0] c, input logic [31:0] top);
    return 8'((c * 32'd255) / top);
  endfunction

  // Predict one result beat and advance the held fit
  function automatic placement_t place_beat(input logic [1:0] user, input logic [87:0] data);
    placement_t  r;
    logic [31:0] cw, ch, iw, ih, fw, fh, scaled_h, px, py, dx, dy, cx, cy;
    logic [23:0] colour;
    r      = '0;
    cw     = 32'(canvas_w);
    ch     = 32'(canvas_h);
    iw     = 32'(data[15:0]);
    ih     = 32'(data[31:16]);
    px     = 32'(data[47:32]);
    py     = 32'(data[63:48]);
    colour = data[87:64];
    if (user[0] == OP_BEGIN) begin
      if (cw == 0 || ch == 0 || iw == 0 || ih == 0 ||
          iw > 32'(MAX_DIMENSION) || ih > 32'(MAX_DIMENSION)) begin
        held.valid = 1'b0;
      end else begin
        fw = iw;
        fh = ih;
        if (iw > cw || ih > ch) begin
          scaled_h = (ih * cw) / iw;
          if (scaled_h <= ch) begin
            fw = cw;
            fh = scaled_h;
          end else begin
            fh = ch;
            fw = (iw * ch) / ih;
          end
        end
        if (fw == 0) fw = 32'd1;
        if (fh == 0) fh = 32'd1;
        held.src_w    = iw[15:0];
        held.src_h    = ih[15:0];
        held.fit_w    = fw[15:0];
        held.fit_h    = fh[15:0];
        held.margin_x = 15'((cw - 32'(fw[15:0])) / 32'd2);
        held.margin_y = 15'((ch - 32'(fh[15:0])) / 32'd2);
        held.valid    = 1'b1;
      end
    end else begin
      if (user[1] == FMT_RGB888) begin
        r.red   = colour[23:16];
        r.green = colour[15:8];
        r.blue  = colour[7:0];
      end else begin
        r.red   = widen_channel(32'(colour[15:11]), 32'd31);
        r.green = widen_channel(32'(colour[10:5]), 32'd63);
        r.blue  = widen_channel(32'(colour[4:0]), 32'd31);
      end
      if (held.valid && held.src_w != 0 && held.src_h != 0 &&
          px < 32'(held.src_w) && py < 32'(held.src_h)) begin
        dx = (px * 32'(held.fit_w)) / 32'(held.src_w);
        dy = (py * 32'(held.fit_h)) / 32'(held.src_h);
        if (dx < 32'(held.fit_w) && dy < 32'(held.fit_h)) begin
          cx = 32'(held.margin_x) + dx;
          cy = 32'(held.margin_y) + dy;
          if (cx < cw && cy < ch) begin
            r.write_enable   = 1'b1;
            r.canvas_address = cy * cw + cx;
          end
        end
      end
    end
    r.fit_ok     = held.valid;
    r.fit_width  = held.fit_w;
    r.fit_height = held.fit_h;
    r.margin_x   = held.margin_x;
    r.margin_y   = held.margin_y;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w = '0;
      canvas_h = '0;
      held     = '0;
      expected_placements.delete();
      waiting  = 0;
    end else begin
      // Compare first: a result beat always belongs to an older input beat
      if (m_tvalid_i && m_tready_i) begin
        seen = placement_t'(m_tdata_i);
        if (expected_placements.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatches++;
        end else begin
          want = expected_placements.pop_front();
          check_field("fit_ok", 32'(want.fit_ok), 32'(seen.fit_ok));
          check_field("fit_width", 32'(want.fit_width), 32'(seen.fit_width));
          check_field("fit_height", 32'(want.fit_height), 32'(seen.fit_height));
          check_field("margin_x", 32'(want.margin_x), 32'(seen.margin_x));
          check_field("margin_y", 32'(want.margin_y), 32'(seen.margin_y));
          check_field("write_enable", 32'(want.write_enable), 32'(seen.write_enable));
          check_field("canvas_address", want.canvas_address, seen.canvas_address);
          check_field("red_out", 32'(want.red), 32'(seen.red));
          check_field("green_out", 32'(want.green), 32'(seen.green));
          check_field("blue_out", 32'(want.blue), 32'(seen.blue));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_placements.push_back(place_beat(s_tuser_i, s_tdata_i));
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_CANVAS_WIDTH) canvas_w = cfg_data_i;
        else canvas_h = cfg_data_i;
      end
      waiting = expected_placements.size();
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the aspect-fit pixel mapper. A directed pass walks
// failed fits, fits kept as is, width- and height-limited scaling, pixels off
// the image and off the canvas and both color formats; then phases of random
// begin and pixel beats run under a range of canvas sizes, with random idling
// on both stream sides. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import afpm_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 6;
  // Slowest beat is a scaling begin; give it headroom
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 20;
  localparam int PHASE_BEATS    = 100;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [87:0]          s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [119:0]         m_axis_tdata;

  int                   mismatch_count;
  int                   pending_count;
  int                   stall_cycles;
  logic                 quiet = 1'b0;      // high: neither side idles
  logic [DIM_W-1:0]     last_src_w;
  logic [DIM_W-1:0]     last_src_h;
  logic [DIM_W-1:0]     phase_cw;
  logic [DIM_W-1:0]     phase_ch;
  int                   phase;
  int                   roll;

  aspect_fit_pixel_mapper_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mapper_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Receiver: drop tready with a chance of 13 in 100 unless quiet
  always @(posedge clk_i) begin
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
  end

  // Watchdog: count cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one beat and hold it until accepted. Leave tvalid high on return
  // so a back-to-back beat never lowers and raises it in the same step.
  task automatic push_beat(input logic [1:0] user, input logic [87:0] data);
    if (!quiet && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 13);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= user;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Begin beat; pixel fields carry noise that the block must ignore
  task automatic send_begin(input logic [15:0] iw, input logic [15:0] ih);
    last_src_w = iw;
    last_src_h = ih;
    push_beat({1'($urandom_range(1)), OP_BEGIN},
              {24'($urandom()), 16'($urandom()), 16'($urandom()), ih, iw});
  endtask

  task automatic send_pixel(input logic fmt, input logic [15:0] px, input logic [15:0] py,
                            input logic [23:0] colour);
    push_beat({fmt, OP_PIXEL}, {colour, py, px, 16'($urandom()), 16'($urandom())});
  endtask

  // Drain the block, let it settle, then write both canvas registers
  task automatic reconfigure(input logic [15:0] cw, input logic [15:0] ch);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_CANVAS_WIDTH;
    cfg_data_i  <= cw;
    @(posedge clk_i);
    cfg_index_i <= REG_CANVAS_HEIGHT;
    cfg_data_i  <= ch;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly small canvases, with the extremes mixed in
  function automatic logic [15:0] pick_canvas_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 15) return 16'd1;
    if (r < 25) return 16'($urandom_range(65535, 1));
    return 16'($urandom_range(320, 8));
  endfunction

  // Source size: fits as is, needs scaling, or breaks the fit
  function automatic logic [15:0] pick_source_dim(input int unsigned canvas);
    int unsigned r, lim;
    r   = $urandom_range(99);
    lim = (canvas == 0) ? 64 : canvas;
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 22) return 16'($urandom_range(65535, 1));
    if (r < 50 && lim < 65535) return 16'($urandom_range((lim * 4 > 65535) ? 65535 : lim * 4,
                                                        lim + 1));
    return 16'($urandom_range(lim, 1));
  endfunction

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_CANVAS_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: canvas still zero after reset, so the fit fails
    send_begin(16'd10, 16'd10);
    send_pixel(FMT_RGB565, 16'd0, 16'd0, 24'h00FFFF);

    reconfigure(16'd320, 16'd240);
    send_begin(16'd100, 16'd50);                         // fits as is, centered
    send_pixel(FMT_RGB565, 16'd0, 16'd0, 24'h000000);
    send_pixel(FMT_RGB888, 16'd99, 16'd49, 24'hFFFFFF);
    send_pixel(FMT_RGB565, 16'd100, 16'd0, 24'hABF81F);  // off image, upper bits set
    send_pixel(FMT_RGB888, 16'd0, 16'd50, 24'h123456);
    send_begin(16'd640, 16'd480);                        // width-limited scaling
    send_pixel(FMT_RGB565, 16'd639, 16'd479, 24'h0007E0);
    send_begin(16'd100, 16'd1000);                       // height-limited scaling
    send_pixel(FMT_RGB888, 16'd99, 16'd999, 24'h5A5A5A);
    send_begin(16'hFFFF, 16'd1);                         // scaled height rounds to zero
    send_pixel(FMT_RGB565, 16'hFFFE, 16'd0, 24'h00F800);
    send_begin(16'd0, 16'd5);                            // zero width fails
    send_pixel(FMT_RGB888, 16'd0, 16'd0, 24'hA5C3E1);
    send_begin(16'd5, 16'd0);
    send_begin(16'hFFFF, 16'hFFFF);
    send_pixel(FMT_RGB888, 16'hFFFF, 16'hFFFF, 24'h010203);

    reconfigure(16'hFFFF, 16'hFFFF);
    send_begin(16'hFFFF, 16'hFFFF);
    send_pixel(FMT_RGB888, 16'hFFFE, 16'hFFFE, 24'hFFFFFF);

    // Shrink the canvas under a held fit: the canvas is read live per pixel
    reconfigure(16'd10, 16'd10);
    send_pixel(FMT_RGB565, 16'd50, 16'd50, 24'h001F);
    send_pixel(FMT_RGB565, 16'd5, 16'd5, 24'h07FF);

    reconfigure(16'd1, 16'd1);
    send_begin(16'd1, 16'd1);
    send_pixel(FMT_RGB888, 16'd0, 16'd0, 24'h800001);

    reconfigure(16'd0, 16'd7);
    send_begin(16'd3, 16'd3);

    // Random phases: new canvas, usually a begin, then mostly in-image pixels.
    // Hold a long stretch with no idling on either side in the middle.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet    <= (phase >= 7 && phase < 10);
      phase_cw = pick_canvas_dim();
      phase_ch = pick_canvas_dim();
      reconfigure(phase_cw, phase_ch);
      // Skip the begin now and then to reuse the held fit on a new canvas
      if ($urandom_range(9) != 0) begin
        send_begin(pick_source_dim(phase_cw), pick_source_dim(phase_ch));
      end
      repeat (PHASE_BEATS) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_begin(pick_source_dim(phase_cw), pick_source_dim(phase_ch));
        end else if (roll < 14 || last_src_w == 0 || last_src_h == 0) begin
          send_pixel(1'($urandom_range(1)), 16'($urandom()), 16'($urandom()),
                     24'($urandom()));
        end else begin
          send_pixel(1'($urandom_range(1)), 16'($urandom_range(last_src_w - 1, 0)),
                     16'($urandom_range(last_src_h - 1, 0)), 24'($urandom()));
        end
      end
    end

    // Drain, then wait out the slowest beat for any stray result
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
